>>> src/vpt_pkg.sv
`timescale 1ns / 1ps
package vpt_pkg;

  localparam int unsigned PARTICLES = 256;
  localparam int unsigned IDX_W     = $clog2(PARTICLES);
  localparam int unsigned CNT_W     = IDX_W + 1;
  localparam int unsigned Q_W       = 24;
  localparam int unsigned DIST_W    = 51;

  typedef enum logic [2:0] {
    CMD_WRITE     = 3'd0,
    CMD_READ      = 3'd1,
    CMD_FORCE     = 3'd2,
    CMD_ACCEL     = 3'd3,
    CMD_INTEGRATE = 3'd4,
    CMD_NEAREST   = 3'd5
  } cmd_e;

  typedef enum logic [1:0] {
    REG_WORLD_WIDTH  = 2'd0,
    REG_WORLD_HEIGHT = 2'd1,
    REG_DAMPING      = 2'd2
  } reg_e;

  typedef struct packed {
    logic signed [Q_W-1:0] pos_x;
    logic signed [Q_W-1:0] pos_y;
    logic signed [Q_W-1:0] prev_x;
    logic signed [Q_W-1:0] prev_y;
    logic signed [Q_W-1:0] acc_x;
    logic signed [Q_W-1:0] acc_y;
    logic        [Q_W-1:0] inv_mass;
    logic                  pinned;
  } entry_t;

  // saturate a 34-bit sum to the Q12.12 range
  function automatic logic signed [Q_W-1:0] sat_q(input logic signed [33:0] v);
    logic signed [33:0] lo;
    logic signed [33:0] hi;
    lo = -34'sd8388608;
    hi = 34'sd8388607;
    if (v < lo) begin
      sat_q = lo[Q_W-1:0];
    end else if (v > hi) begin
      sat_q = hi[Q_W-1:0];
    end else begin
      sat_q = v[Q_W-1:0];
    end
  endfunction

endpackage

>>> src/vpt_div.sv
`timescale 1ns / 1ps
module vpt_div
  import vpt_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [15:0] dt_i,
  input  logic [15:0] pdt_i,
  output logic        done_o,
  output logic [31:0] quot_o
);

  logic [5:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic [15:0] rem_q, rem_d;
  logic [31:0] num_q, num_d;
  logic [31:0] quot_q, quot_d;
  logic [15:0] den_q, den_d;
  logic [16:0] rem_sh;
  logic [16:0] rem_sub;

  assign rem_sh  = {rem_q, num_q[31]};
  assign rem_sub = rem_sh - {1'b0, den_q};

  always_comb begin
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    rem_d  = rem_q;
    num_d  = num_q;
    quot_d = quot_q;
    den_d  = den_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = 6'd0;
      rem_d  = 16'd0;
      num_d  = {dt_i, 16'd0};
      den_d  = (pdt_i == 16'd0) ? 16'd1 : pdt_i;
    end else if (busy_q) begin
      num_d = {num_q[30:0], 1'b0};
      if (rem_sh >= {1'b0, den_q}) begin
        rem_d  = rem_sub[15:0];
        quot_d = {quot_q[30:0], 1'b1};
      end else begin
        rem_d  = rem_sh[15:0];
        quot_d = {quot_q[30:0], 1'b0};
      end
      cnt_d = cnt_q + 6'd1;
      if (cnt_q == 6'd31) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    num_q  <= num_d;
    quot_q <= quot_d;
    den_q  <= den_d;
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

>>> src/verlet_particle_table_unit.sv
`timescale 1ns / 1ps
// channel | direction | handshake               | payload
// in      | input     | in_valid_i / in_ready_o | cmd, index, value_x/y, inverse_mass, pinned,
//         |           |                         | live, step_time, prev_step_time
// out     | output    | out_valid_o/out_ready_i | status, result_index, result_x/y, result_pinned
// cfg     | input     | cfg_we_i                | cfg_index_i, cfg_wdata_i
// Write and unknown items pass through the exec and resp states, read adds a read state;
// force, accel and nearest sweep the particle memory one slot a cycle; integrate first
// runs the serial divider for the step ratio. The single read port sets the sweep.
// Reset clears the live flags and control; no clearing pass. A result waiting on out
// holds the next item in its last cycle only.
module verlet_particle_table_unit
  import vpt_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [2:0]            cmd_i,
  input  logic [7:0]            index_i,
  input  logic signed [23:0]    value_x_i,
  input  logic signed [23:0]    value_y_i,
  input  logic [23:0]           inverse_mass_i,
  input  logic                  pinned_i,
  input  logic                  live_i,
  input  logic [15:0]           step_time_i,
  input  logic [15:0]           prev_step_time_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic                  status_o,
  output logic [7:0]            result_index_o,
  output logic signed [23:0]    result_x_o,
  output logic signed [23:0]    result_y_o,
  output logic                  result_pinned_o,
  input  logic                  cfg_we_i,
  input  logic [1:0]            cfg_index_i,
  input  logic [15:0]           cfg_wdata_i
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_EXEC  = 3'd1;
  localparam logic [2:0] ST_READ  = 3'd2;
  localparam logic [2:0] ST_DIV   = 3'd3;
  localparam logic [2:0] ST_SWEEP = 3'd4;
  localparam logic [2:0] ST_RESP  = 3'd5;

  logic [2:0] state_q, state_d;

  // configuration
  logic [10:0] width_q, height_q;
  logic [15:0] damp_q;

  // held item
  logic [2:0]             cmd_q;
  logic [IDX_W-1:0]       idx_q;
  logic signed [Q_W-1:0]  vx_q, vy_q;
  logic [Q_W-1:0]         inv_q;
  logic                   pin_q, live_in_q;
  logic [15:0]            dt_q, pdt_q;
  logic [31:0]            dt2_q;

  // result
  logic                   out_valid_q;
  logic                   res_status_q;
  logic [IDX_W-1:0]       res_idx_q;
  logic signed [Q_W-1:0]  res_x_q, res_y_q;
  logic                   res_pin_q;
  logic                   o_status_q;
  logic [IDX_W-1:0]       o_idx_q;
  logic signed [Q_W-1:0]  o_x_q, o_y_q;
  logic                   o_pin_q;

  // memory
  entry_t                 mem [PARTICLES];
  logic                   rd_en;
  logic [IDX_W-1:0]       rd_addr;
  entry_t                 rd_q;
  logic                   we;
  logic [IDX_W-1:0]       wa;
  entry_t                 wd;
  logic [PARTICLES-1:0]   live_q;

  // divider
  logic                   div_start;
  logic                   div_done;
  logic [31:0]            ratio;

  // sweep
  logic [CNT_W-1:0]       cnt_q;
  logic                   issue;
  logic                   s1_valid_q, s2_valid_q, s3_valid_q;
  logic [IDX_W-1:0]       s1_addr_q, s2_addr_q, s3_addr_q;
  logic                   s1_live_q, s2_live_q, s3_live_q;
  entry_t                 s2_e_q, s3_e_q;

  // stage 1 products
  logic signed [24:0]     velx, vely, dx, dy;
  logic signed [41:0]     mdx, mdy, mdx_q, mdy_q;
  logic signed [56:0]     pushx, pushy;
  logic signed [24:0]     pushx_q, pushy_q;
  logic signed [48:0]     fmx, fmy, fmx_q, fmy_q;
  logic signed [49:0]     dsqx, dsqy;
  logic [49:0]            dsqx_q, dsqy_q;

  // stage 2
  logic signed [25:0]     in1x, in1y;
  logic signed [42:0]     lox, loy, hix, hiy, lox_q, loy_q, hix_q, hiy_q;
  logic signed [Q_W-1:0]  nacc_x, nacc_y;
  logic signed [Q_W-1:0]  s3_acc_x_q, s3_acc_y_q;
  logic [DIST_W-1:0]      dist_sq;
  logic                   found_q;
  logic [DIST_W-1:0]      best_q;
  logic [IDX_W-1:0]       best_idx_q;
  logic signed [Q_W-1:0]  best_x_q, best_y_q;
  logic                   best_pin_q;

  // stage 3
  logic signed [44:0]     sumx, sumy;
  logic signed [Q_W-1:0]  clx, cly;
  logic signed [44:0]     wx, wy;
  logic                   sweep_done;

  function automatic logic signed [Q_W-1:0] clamp_box(input logic signed [44:0] v,
                                                      input logic signed [44:0] hi);
    if (v < 45'sd0) begin
      clamp_box = '0;
    end else if (v > hi) begin
      clamp_box = hi[Q_W-1:0];
    end else begin
      clamp_box = v[Q_W-1:0];
    end
  endfunction

  assign in_ready_o = (state_q == ST_IDLE);

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= 11'd800;
      height_q <= 11'd600;
      damp_q   <= 16'd64881;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_WORLD_WIDTH:  width_q  <= cfg_wdata_i[10:0];
        REG_WORLD_HEIGHT: height_q <= cfg_wdata_i[10:0];
        REG_DAMPING:      damp_q   <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      cmd_q     <= cmd_i;
      idx_q     <= index_i;
      vx_q      <= value_x_i;
      vy_q      <= value_y_i;
      inv_q     <= inverse_mass_i;
      pin_q     <= pinned_i;
      live_in_q <= live_i;
      dt_q      <= step_time_i;
      pdt_q     <= prev_step_time_i;
    end
    if (state_q == ST_EXEC) begin
      dt2_q <= dt_q * dt_q;
    end
  end

  vpt_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .dt_i    (dt_q),
    .pdt_i   (pdt_q),
    .done_o  (div_done),
    .quot_o  (ratio)
  );

  assign div_start = (state_q == ST_EXEC) && (cmd_q == CMD_INTEGRATE);

  assign issue      = (state_q == ST_SWEEP) && !cnt_q[CNT_W-1];
  assign sweep_done = (state_q == ST_SWEEP) && cnt_q[CNT_W-1]
                      && !s1_valid_q && !s2_valid_q && !s3_valid_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (in_valid_i) state_d = ST_EXEC;
      ST_EXEC: begin
        unique case (cmd_q)
          CMD_READ:                         state_d = ST_READ;
          CMD_INTEGRATE:                    state_d = ST_DIV;
          CMD_FORCE, CMD_ACCEL, CMD_NEAREST: state_d = ST_SWEEP;
          default:                          state_d = ST_RESP;
        endcase
      end
      ST_READ:  state_d = ST_RESP;
      ST_DIV:   if (div_done) state_d = ST_SWEEP;
      ST_SWEEP: if (sweep_done) state_d = ST_RESP;
      ST_RESP:  if (!out_valid_q || out_ready_i) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      s3_valid_q  <= 1'b0;
      live_q      <= '0;
      found_q     <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_RESP && (!out_valid_q || out_ready_i)) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (state_q == ST_EXEC) begin
        cnt_q   <= '0;
        found_q <= 1'b0;
      end else if (issue) begin
        cnt_q <= cnt_q + 1'b1;
      end
      s1_valid_q <= issue;
      s2_valid_q <= s1_valid_q;
      s3_valid_q <= s2_valid_q;
      if (state_q == ST_EXEC && cmd_q == CMD_WRITE) begin
        live_q[idx_q] <= live_in_q;
      end
      if (s2_valid_q && s2_live_q && cmd_q == CMD_NEAREST) begin
        found_q <= 1'b1;
      end
    end
  end

  // memory, one read and one write port
  assign rd_en   = issue || (state_q == ST_EXEC && cmd_q == CMD_READ);
  assign rd_addr = (state_q == ST_EXEC) ? idx_q : cnt_q[IDX_W-1:0];

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
    if (we) begin
      mem[wa] <= wd;
    end
  end

  // stage 1
  assign velx  = 25'(rd_q.pos_x) - 25'(rd_q.prev_x);
  assign vely  = 25'(rd_q.pos_y) - 25'(rd_q.prev_y);
  assign mdx   = velx * $signed({1'b0, damp_q});
  assign mdy   = vely * $signed({1'b0, damp_q});
  assign pushx = rd_q.acc_x * $signed({1'b0, dt2_q});
  assign pushy = rd_q.acc_y * $signed({1'b0, dt2_q});
  assign fmx   = vx_q * $signed({1'b0, rd_q.inv_mass});
  assign fmy   = vy_q * $signed({1'b0, rd_q.inv_mass});
  assign dx    = 25'(rd_q.pos_x) - 25'(vx_q);
  assign dy    = 25'(rd_q.pos_y) - 25'(vy_q);
  assign dsqx  = dx * dx;
  assign dsqy  = dy * dy;

  always_ff @(posedge clk_i) begin
    s1_addr_q <= cnt_q[IDX_W-1:0];
    s1_live_q <= live_q[cnt_q[IDX_W-1:0]];
    s2_addr_q <= s1_addr_q;
    s2_live_q <= s1_live_q;
    s2_e_q    <= rd_q;
    mdx_q     <= mdx;
    mdy_q     <= mdy;
    pushx_q   <= pushx[56:32];
    pushy_q   <= pushy[56:32];
    fmx_q     <= fmx;
    fmy_q     <= fmy;
    dsqx_q    <= dsqx[49:0];
    dsqy_q    <= dsqy[49:0];
  end

  // stage 2
  assign in1x    = mdx_q[41:16];
  assign in1y    = mdy_q[41:16];
  assign lox     = in1x * $signed({1'b0, ratio[15:0]});
  assign loy     = in1y * $signed({1'b0, ratio[15:0]});
  assign hix     = in1x * $signed({1'b0, ratio[31:16]});
  assign hiy     = in1y * $signed({1'b0, ratio[31:16]});
  assign dist_sq = DIST_W'(dsqx_q) + DIST_W'(dsqy_q);

  always_comb begin
    if (cmd_q == CMD_FORCE) begin
      nacc_x = sat_q(34'(s2_e_q.acc_x) + 34'($signed(fmx_q[48:16])));
      nacc_y = sat_q(34'(s2_e_q.acc_y) + 34'($signed(fmy_q[48:16])));
    end else begin
      nacc_x = sat_q(34'(s2_e_q.acc_x) + 34'(vx_q));
      nacc_y = sat_q(34'(s2_e_q.acc_y) + 34'(vy_q));
    end
  end

  logic signed [24:0] s3_pushx_q, s3_pushy_q;

  always_ff @(posedge clk_i) begin
    s3_addr_q  <= s2_addr_q;
    s3_live_q  <= s2_live_q;
    s3_e_q     <= s2_e_q;
    lox_q      <= lox;
    loy_q      <= loy;
    hix_q      <= hix;
    hiy_q      <= hiy;
    s3_acc_x_q <= nacc_x;
    s3_acc_y_q <= nacc_y;
    s3_pushx_q <= pushx_q;
    s3_pushy_q <= pushy_q;
    if (s2_valid_q && s2_live_q && cmd_q == CMD_NEAREST && (!found_q || dist_sq < best_q)) begin
      best_q     <= dist_sq;
      best_idx_q <= s2_addr_q;
      best_x_q   <= s2_e_q.pos_x;
      best_y_q   <= s2_e_q.pos_y;
      best_pin_q <= s2_e_q.pinned;
    end
  end

  // stage 3: sum, clamp, write back
  assign wx = 45'({width_q, 12'd0});
  assign wy = 45'({height_q, 12'd0});

  always_comb begin
    if (s3_e_q.pinned) begin
      sumx = 45'(s3_e_q.pos_x);
      sumy = 45'(s3_e_q.pos_y);
    end else begin
      sumx = 45'(s3_e_q.pos_x) + 45'(hix_q) + 45'($signed(lox_q[42:16])) + 45'(s3_pushx_q);
      sumy = 45'(s3_e_q.pos_y) + 45'(hiy_q) + 45'($signed(loy_q[42:16])) + 45'(s3_pushy_q);
    end
    clx = clamp_box(sumx, wx);
    cly = clamp_box(sumy, wy);
  end

  always_comb begin
    we = 1'b0;
    wa = s3_addr_q;
    wd = s3_e_q;
    if (state_q == ST_EXEC && cmd_q == CMD_WRITE) begin
      we          = 1'b1;
      wa          = idx_q;
      wd.pos_x    = vx_q;
      wd.pos_y    = vy_q;
      wd.prev_x   = vx_q;
      wd.prev_y   = vy_q;
      wd.acc_x    = '0;
      wd.acc_y    = '0;
      wd.inv_mass = inv_q;
      wd.pinned   = pin_q;
    end else if (s3_valid_q && s3_live_q) begin
      case (cmd_q)
        CMD_FORCE, CMD_ACCEL: begin
          we       = !s3_e_q.pinned;
          wd.acc_x = s3_acc_x_q;
          wd.acc_y = s3_acc_y_q;
        end
        CMD_INTEGRATE: begin
          we       = 1'b1;
          wd.pos_x = clx;
          wd.pos_y = cly;
          if (!s3_e_q.pinned) begin
            wd.prev_x = s3_e_q.pos_x;
            wd.prev_y = s3_e_q.pos_y;
            wd.acc_x  = '0;
            wd.acc_y  = '0;
          end
        end
        default: ;
      endcase
    end
  end

  // result assembly
  always_ff @(posedge clk_i) begin
    if (state_q == ST_EXEC) begin
      res_status_q <= 1'b0;
      res_idx_q    <= idx_q;
      res_x_q      <= '0;
      res_y_q      <= '0;
      res_pin_q    <= 1'b0;
    end else if (state_q == ST_READ) begin
      res_x_q   <= rd_q.pos_x;
      res_y_q   <= rd_q.pos_y;
      res_pin_q <= rd_q.pinned;
    end else if (sweep_done && cmd_q == CMD_NEAREST) begin
      res_status_q <= !found_q;
      res_idx_q    <= found_q ? best_idx_q : '0;
      res_x_q      <= found_q ? best_x_q : '0;
      res_y_q      <= found_q ? best_y_q : '0;
      res_pin_q    <= found_q ? best_pin_q : 1'b0;
    end
    if (state_q == ST_RESP && (!out_valid_q || out_ready_i)) begin
      o_status_q <= res_status_q;
      o_idx_q    <= res_idx_q;
      o_x_q      <= res_x_q;
      o_y_q      <= res_y_q;
      o_pin_q    <= res_pin_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = o_status_q;
  assign result_index_o  = o_idx_q;
  assign result_x_o      = o_x_q;
  assign result_y_o      = o_y_q;
  assign result_pinned_o = o_pin_q;

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps
module tb;
  import vpt_pkg::*;

  localparam logic [2:0] CMD_SPARE_A = 3'd6;
  localparam logic [2:0] CMD_SPARE_B = 3'd7;
  localparam longint     Q_LO        = -64'sd8388608;
  localparam longint     Q_HI        = 64'sd8388607;
  localparam longint     CYCLE_LIMIT = 3000000;

  typedef struct {
    logic [2:0]         cmd;
    logic [7:0]         idx;
    logic signed [23:0] vx;
    logic signed [23:0] vy;
    logic [23:0]        inv;
    logic               pin;
    logic               liv;
    logic [15:0]        dt;
    logic [15:0]        pdt;
  } item_t;

  typedef struct {
    logic               status;
    logic [7:0]         ridx;
    logic signed [23:0] rx;
    logic signed [23:0] ry;
    logic               rpin;
  } result_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  logic [2:0]         cmd_i = '0;
  logic [7:0]         index_i = '0;
  logic signed [23:0] value_x_i = '0;
  logic signed [23:0] value_y_i = '0;
  logic [23:0]        inverse_mass_i = '0;
  logic               pinned_i = 1'b0;
  logic               live_i = 1'b0;
  logic [15:0]        step_time_i = '0;
  logic [15:0]        prev_step_time_i = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic               status_o;
  logic [7:0]         result_index_o;
  logic signed [23:0] result_x_o;
  logic signed [23:0] result_y_o;
  logic               result_pinned_o;
  logic               cfg_we_i = 1'b0;
  logic [1:0]         cfg_index_i = '0;
  logic [15:0]        cfg_wdata_i = '0;

  verlet_particle_table_unit i_dut (.*);

  always #5 clk_i = ~clk_i;

  // particle table shadow
  longint    px [PARTICLES];
  longint    py [PARTICLES];
  longint    ox [PARTICLES];
  longint    oy [PARTICLES];
  longint    ax [PARTICLES];
  longint    ay [PARTICLES];
  longint    inv_m [PARTICLES];
  bit        pin_f [PARTICLES];
  bit        live_f [PARTICLES];
  bit        written [PARTICLES];
  longint    width_r, height_r, damp_r;

  result_t   pending_results[$];
  int        errors, items_sent, results_seen, send_idle_pct, recv_stall_pct;
  longint    cycles;

  task automatic report(input string what, input longint got, input longint want);
    $display("mismatch %0s: got %0d expected %0d (result %0d)", what, got, want,
             results_seen);
    errors++;
  endtask

  function automatic longint clampl(input longint v, input longint lo, input longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint verlet_step(input longint p, input longint o, input longint a,
                                         input longint ratio, input longint dt2,
                                         input longint hi);
    longint inertia;
    inertia = ((p - o) * damp_r) >>> 16;
    inertia = (inertia * ratio) >>> 16;
    return clampl(p + inertia + ((a * dt2) >>> 32), 0, hi);
  endfunction

  function automatic result_t predict_table(input item_t it);
    result_t r;
    longint  ratio, dt2, wx, wy, best, d, dx, dy, vx, vy;
    int      bi;
    bit      found;
    vx = it.vx;
    vy = it.vy;
    r = '{1'b0, it.idx, '0, '0, 1'b0};
    case (it.cmd)
      CMD_WRITE: begin
        px[it.idx] = vx; ox[it.idx] = vx;
        py[it.idx] = vy; oy[it.idx] = vy;
        ax[it.idx] = 0; ay[it.idx] = 0;
        inv_m[it.idx] = it.inv;
        pin_f[it.idx] = it.pin;
        live_f[it.idx] = it.liv;
        written[it.idx] = 1'b1;
      end
      CMD_READ: begin
        r.rx = 24'(px[it.idx]); r.ry = 24'(py[it.idx]); r.rpin = pin_f[it.idx];
      end
      CMD_FORCE, CMD_ACCEL: begin
        for (int i = 0; i < PARTICLES; i++) begin
          if (!live_f[i] || pin_f[i]) continue;
          if (it.cmd == CMD_FORCE) begin
            ax[i] = clampl(ax[i] + ((vx * inv_m[i]) >>> 16), Q_LO, Q_HI);
            ay[i] = clampl(ay[i] + ((vy * inv_m[i]) >>> 16), Q_LO, Q_HI);
          end else begin
            ax[i] = clampl(ax[i] + vx, Q_LO, Q_HI);
            ay[i] = clampl(ay[i] + vy, Q_LO, Q_HI);
          end
        end
      end
      CMD_INTEGRATE: begin
        ratio = (longint'(it.dt) << 16) / (it.pdt == 0 ? 1 : longint'(it.pdt));
        dt2 = longint'(it.dt) * longint'(it.dt);
        wx = width_r << 12;
        wy = height_r << 12;
        for (int i = 0; i < PARTICLES; i++) begin
          if (!live_f[i]) continue;
          if (pin_f[i]) begin
            px[i] = clampl(px[i], 0, wx);
            py[i] = clampl(py[i], 0, wy);
          end else begin
            dx = verlet_step(px[i], ox[i], ax[i], ratio, dt2, wx);
            dy = verlet_step(py[i], oy[i], ay[i], ratio, dt2, wy);
            ox[i] = px[i]; oy[i] = py[i];
            px[i] = dx; py[i] = dy;
            ax[i] = 0; ay[i] = 0;
          end
        end
      end
      CMD_NEAREST: begin
        found = 1'b0;
        best = 0;
        bi = 0;
        for (int i = 0; i < PARTICLES; i++) begin
          if (!live_f[i]) continue;
          dx = px[i] - vx;
          dy = py[i] - vy;
          d = dx * dx + dy * dy;
          if (!found || d < best) begin
            found = 1'b1; best = d; bi = i;
          end
        end
        if (found) begin
          r.ridx = bi[7:0]; r.rx = 24'(px[bi]); r.ry = 24'(py[bi]); r.rpin = pin_f[bi];
        end else begin
          r.status = 1'b1; r.ridx = '0;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic send_item(input item_t it);
    bit taken;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i       <= 1'b1;
    cmd_i            <= it.cmd;
    index_i          <= it.idx;
    value_x_i        <= it.vx;
    value_y_i        <= it.vy;
    inverse_mass_i   <= it.inv;
    pinned_i         <= it.pin;
    live_i           <= it.liv;
    step_time_i      <= it.dt;
    prev_step_time_i <= it.pdt;
    do begin
      @(negedge clk_i);
      taken = in_ready_o;
      @(posedge clk_i);
    end while (!taken);
    pending_results.insert(pending_results.size(), predict_table(it));
    items_sent++;
  endtask

  function automatic item_t make_item(input logic [2:0] c, input int i, input longint x,
                                      input longint y);
    item_t it;
    it = '{c, i[7:0], x[23:0], y[23:0], 24'h010000, 1'b0, 1'b1, 16'd1092, 16'd1092};
    return it;
  endfunction

  task automatic drain;
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (5) @(posedge clk_i);
  endtask

  task automatic write_reg(input reg_e r, input logic [15:0] v);
    drain();
    cfg_we_i    <= 1'b1;
    cfg_index_i <= r;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    case (r)
      REG_WORLD_WIDTH:  width_r = v[10:0];
      REG_WORLD_HEIGHT: height_r = v[10:0];
      default:          damp_r = v;
    endcase
  endtask

  task automatic set_box(input int w, input int h, input int d);
    write_reg(REG_WORLD_WIDTH, w[15:0]);
    write_reg(REG_WORLD_HEIGHT, h[15:0]);
    write_reg(REG_DAMPING, d[15:0]);
  endtask

  task automatic test_directed;
    item_t it;
    send_item(make_item(CMD_NEAREST, 9, 0, 0));           // empty table
    send_item(make_item(CMD_WRITE, 0, Q_HI, Q_LO));
    it = make_item(CMD_WRITE, 255, Q_LO, Q_HI);
    it.inv = 24'hFFFFFF;
    send_item(it);
    it = make_item(CMD_WRITE, 7, 100 << 12, 100 << 12);
    it.pin = 1'b1;
    send_item(it);
    it = make_item(CMD_WRITE, 8, 50 << 12, 60 << 12);
    it.inv = '0;
    send_item(it);
    send_item(make_item(CMD_WRITE, 9, 50 << 12, 60 << 12));  // tie with slot 8
    send_item(make_item(CMD_READ, 0, 0, 0));
    send_item(make_item(CMD_READ, 7, 0, 0));
    send_item(make_item(CMD_NEAREST, 3, 50 << 12, 60 << 12));
    send_item(make_item(CMD_ACCEL, 0, Q_HI, Q_LO));
    send_item(make_item(CMD_ACCEL, 0, Q_HI, Q_LO));          // saturates
    send_item(make_item(CMD_FORCE, 0, Q_LO, Q_HI));
    it = make_item(CMD_INTEGRATE, 0, 0, 0);
    it.dt = 16'hFFFF; it.pdt = 16'd1;
    send_item(it);
    it.dt = 16'd1; it.pdt = 16'd0;                            // zero previous step
    send_item(it);
    it.dt = 16'd0; it.pdt = 16'hFFFF;
    send_item(it);
    send_item(make_item(CMD_READ, 255, 0, 0));
    send_item(make_item(CMD_READ, 7, 0, 0));
    send_item(make_item(CMD_SPARE_A, 170, Q_HI, Q_HI));
    send_item(make_item(CMD_SPARE_B, 85, Q_LO, Q_LO));
    it = make_item(CMD_WRITE, 9, 0, 0);
    it.liv = 1'b0;                                            // removal
    send_item(it);
    send_item(make_item(CMD_NEAREST, 1, Q_HI, Q_HI));
  endtask

  task automatic test_random(input int count);
    item_t it;
    int    pick, tries;
    for (int n = 0; n < count; n++) begin
      it.idx = 8'($urandom_range(255));
      it.vx = $urandom_range(2) == 0 ? 24'($urandom) : 24'($urandom_range(width_r << 12));
      it.vy = $urandom_range(2) == 0 ? 24'($urandom) : 24'($urandom_range(height_r << 12));
      it.inv = $urandom_range(3) == 0 ? 24'($urandom) : 24'($urandom_range(24'h02_0000));
      it.pin = ($urandom_range(4) == 0);
      it.liv = ($urandom_range(5) != 0);
      it.dt = $urandom_range(3) == 0 ? 16'($urandom) : 16'($urandom_range(800, 1400));
      it.pdt = $urandom_range(3) == 0 ? 16'($urandom) : 16'($urandom_range(800, 1400));
      pick = $urandom_range(99);
      if (pick < 28) it.cmd = CMD_WRITE;
      else if (pick < 46) it.cmd = CMD_READ;
      else if (pick < 56) it.cmd = CMD_FORCE;
      else if (pick < 66) it.cmd = CMD_ACCEL;
      else if (pick < 82) it.cmd = CMD_INTEGRATE;
      else if (pick < 96) it.cmd = CMD_NEAREST;
      else it.cmd = $urandom_range(1) ? CMD_SPARE_A : CMD_SPARE_B;
      // reads go only to slots that hold a particle
      if (it.cmd == CMD_READ) begin
        tries = 0;
        while (!written[it.idx] && tries < 64) begin
          it.idx = 8'($urandom_range(255));
          tries++;
        end
        if (!written[it.idx]) it.cmd = CMD_WRITE;
      end
      send_item(it);
    end
  endtask

  task automatic run_phase(input int idle, input int stall, input int count);
    drain();
    send_idle_pct = idle;
    recv_stall_pct = stall;
    test_random(count);
  endtask

  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("*** FAILED ***");
      $finish;
    end
  end

  // the handshake seen here completes at the next rising edge
  always @(negedge clk_i) begin
    result_t e;
    if (rst_ni && out_valid_o && out_ready_i) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        report("unexpected item, index", result_index_o, 0);
      end else begin
        e = pending_results.pop_front();
        if (status_o !== e.status) report("status", status_o, e.status);
        if (result_index_o !== e.ridx) report("result_index", result_index_o, e.ridx);
        if (result_x_o !== e.rx) report("result_x", result_x_o, e.rx);
        if (result_y_o !== e.ry) report("result_y", result_y_o, e.ry);
        if (result_pinned_o !== e.rpin) report("result_pinned", result_pinned_o, e.rpin);
      end
    end
  end

  initial begin
    for (int i = 0; i < PARTICLES; i++) begin
      live_f[i] = 1'b0; written[i] = 1'b0; pin_f[i] = 1'b0;
      px[i] = 0; py[i] = 0; ox[i] = 0; oy[i] = 0; ax[i] = 0; ay[i] = 0; inv_m[i] = 0;
    end
    width_r = 800; height_r = 600; damp_r = 64881;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    run_phase(0, 0, 140);
    set_box(1, 1, 0);
    run_phase(87, 0, 50);
    set_box(2047, 2047, 65535);
    run_phase(87, 0, 90);
    set_box($urandom_range(1, 2047), $urandom_range(1, 2047), $urandom_range(65535));
    run_phase(0, 87, 140);
    set_box(800, 600, 64881);
    run_phase(35, 35, 130);
    drain();
    repeat (20) @(posedge clk_i);
    $display("%0d items sent, %0d results checked over directed cases,", items_sent,
             results_seen);
    $display("four box settings and four flow-control phases; %0d mismatches", errors);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
